[rtl/rgb_led_ring_engine_macros.svh]
// assertion macros for the led ring engine
`ifndef RGB_LED_RING_ENGINE_MACROS_SVH
`define RGB_LED_RING_ENGINE_MACROS_SVH

// same-cycle implication, disabled in reset
`define RGBR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RGBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rgbr_pkg.sv]
// types, codes and helper functions shared by the led ring engine
package rgbr_pkg;

    localparam int RGBR_LED_COUNT = 16;
    localparam int RGBR_IDX_W     = 4;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_FADE   = 3'd1,
        OP_SET    = 3'd2,
        OP_GLOW   = 3'd3,
        OP_ROTATE = 3'd4,
        OP_SHOW   = 3'd5
    } rgbr_op_t;

    typedef enum logic [2:0] {
        CMAP_DIRECT   = 3'd0,
        CMAP_GREY     = 3'd1,
        CMAP_STOP     = 3'd2,
        CMAP_BLUE_RED = 3'd3,
        CMAP_RED      = 3'd4,
        CMAP_GREEN    = 3'd5,
        CMAP_BLUE     = 3'd6
    } rgbr_cmap_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_PASS,
        ST_ROT
    } rgbr_state_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgbr_led_t;

    typedef struct packed {
        rgbr_op_t                op;
        logic [RGBR_IDX_W-1:0]   led_index;
        logic                    all_leds;
        rgbr_led_t               col;
        logic [7:0]              step;
    } rgbr_cmd_t;

    typedef struct packed {
        logic clear;
        logic shift_up;
        logic shift_down;
    } rgbr_cell_ctrl_t;

    // one fade step on one channel, clamped at the target
    function automatic logic [7:0] fade_ch(input logic [7:0] cur, input logic [7:0] tgt,
                                           input logic [7:0] stp);
        logic [8:0] t_plus_s;
        logic [8:0] c_plus_s;
        logic [7:0] res;
        t_plus_s = {1'b0, tgt} + {1'b0, stp};
        c_plus_s = {1'b0, cur} + {1'b0, stp};
        if (cur > tgt)
        begin
            res = ({1'b0, cur} <= t_plus_s) ? tgt : 8'(cur - stp);
        end
        else
        begin
            res = (c_plus_s >= {1'b0, tgt}) ? tgt : c_plus_s[7:0];
        end
        return res;
    endfunction

    // colour for the angle commands
    function automatic rgbr_led_t pick_colour(input logic [2:0] cmap, input logic [11:0] v,
                                              input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
        rgbr_led_t  col;
        logic [7:0] hi;
        hi = v[11:4];
        case (rgbr_cmap_t'(cmap))
            CMAP_GREY:
            begin
                col = '{r: hi, g: hi, b: hi};
            end
            CMAP_STOP:
            begin
                if (!v[11])
                begin
                    col = '{r: v[10:3], g: 8'hFF, b: 8'h00};
                end
                else
                begin
                    col = '{r: 8'hFF, g: 8'(8'hFF - v[10:3]), b: 8'h00};
                end
            end
            CMAP_BLUE_RED:
            begin
                col = '{r: hi, g: 8'h00, b: 8'(8'hFF - hi)};
            end
            CMAP_RED:
            begin
                col = '{r: hi, g: 8'h00, b: 8'h00};
            end
            CMAP_GREEN:
            begin
                col = '{r: 8'h00, g: hi, b: 8'h00};
            end
            CMAP_BLUE:
            begin
                col = '{r: 8'h00, g: 8'h00, b: hi};
            end
            default:
            begin
                col = '{r: r, g: g, b: b};
            end
        endcase
        return col;
    endfunction

endpackage

[rtl/rgbr_if.sv]
// command and led word channels
interface rgbr_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [3:0]         led_index;
    logic               all_leds;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         step;
    logic signed [15:0] heading;
    logic signed [15:0] rotate_period;
    logic [2:0]         color_map;
    logic [11:0]        color_value;

    modport source (
        output valid, operation, led_index, all_leds, red, green, blue, step,
               heading, rotate_period, color_map, color_value,
        input  ready
    );
    modport sink (
        input  valid, operation, led_index, all_leds, red, green, blue, step,
               heading, rotate_period, color_map, color_value,
        output ready
    );
endinterface

interface rgbr_led_if;
    logic        valid;
    logic        ready;
    logic [3:0]  out_index;
    logic [11:0] out_red;
    logic [11:0] out_green;
    logic [11:0] out_blue;
    logic        last;

    modport source (
        output valid, out_index, out_red, out_green, out_blue, last,
        input  ready
    );
    modport sink (
        input  valid, out_index, out_red, out_green, out_blue, last,
        output ready
    );
endinterface

[rtl/rgb_led_ring_engine.sv]
// top level of the led ring engine: control, cell chain and output register
`include "rgb_led_ring_engine_macros.svh"

// The ring of 16 RGB leds lives in a chain of cells. Commands are taken one at a
// time on cmd; ready is high only while the engine is idle. clear acts in the
// accept cycle and rotate_tick in the ST_ROT state that follows it. fade_to and
// show: after the accept cycle the whole ring circulates once through the chain
// and the update unit at its wrap point sees each led in turn; show loads led k
// into the led output register at the k-th step of the circulation and holds the
// circulation whenever that register is still full and not taken. set_angle and
// glow_angle pass through the heading mapper (ST_ANGLE) between the accept cycle
// and the circulation. The next command may be accepted while the last led word
// of a show still waits on led.
module rgb_led_ring_engine
    import rgbr_pkg::*;
#(
    parameter int LED_COUNT = RGBR_LED_COUNT
)
(
    input  logic       clk,
    input  logic       rst_n,
    rgbr_cmd_if.sink   cmd,
    rgbr_led_if.source led
);

    localparam int IDX_W = $clog2(LED_COUNT);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(LED_COUNT - 1);

    rgbr_state_t state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [15:0] ticks_reg, ticks_next;
    rgbr_cmd_t cmd_reg;
    logic signed [15:0] period_reg;

    logic      out_valid_reg, out_valid_next;
    rgbr_led_t out_led_reg;
    logic [RGBR_IDX_W-1:0] out_index_reg;
    logic      out_last_reg;

    logic accept;
    logic show_pass;
    logic adv;
    logic pass_done;
    logic hd_start;
    logic hd_done;
    logic [RGBR_IDX_W-1:0] centre;
    logic [15:0] ticks_inc;
    logic [15:0] mag;
    logic rot_hit;
    logic rot_up;

    rgbr_cell_ctrl_t cell_ctrl;
    rgbr_led_t       ring [LED_COUNT];
    rgbr_led_t       head_out;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign hd_start  = accept && ((rgbr_op_t'(cmd.operation) == OP_SET) ||
                                  (rgbr_op_t'(cmd.operation) == OP_GLOW));

    // circulation steps unless a show word is stuck in the output register
    assign show_pass = (cmd_reg.op == OP_SHOW);
    assign adv       = (state_reg == ST_PASS) && (!show_pass || !out_valid_reg || led.ready);
    assign pass_done = adv && (cnt_reg == LAST_POS);

    // tick counter and rotation decision
    always_comb
    begin
        ticks_inc = (ticks_reg != 16'hFFFF) ? ticks_reg + 16'd1 : ticks_reg;
        mag       = period_reg[15] ? 16'(-period_reg) : 16'(period_reg);
        rot_hit   = (period_reg != 16'sd0) && (ticks_inc >= mag);
        rot_up    = !period_reg[15];
    end

    // command register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.op        <= rgbr_op_t'(cmd.operation);
            cmd_reg.led_index <= cmd.led_index;
            cmd_reg.all_leds  <= cmd.all_leds;
            cmd_reg.step      <= cmd.step;
            if (rgbr_op_t'(cmd.operation) == OP_FADE)
            begin
                cmd_reg.col <= '{r: cmd.red, g: cmd.green, b: cmd.blue};
            end
            else
            begin
                cmd_reg.col <= pick_colour(cmd.color_map, cmd.color_value,
                                           cmd.red, cmd.green, cmd.blue);
            end
            period_reg <= cmd.rotate_period;
        end
    end

    // next state and cell control
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ticks_next = ticks_reg;
        cell_ctrl  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    case (rgbr_op_t'(cmd.operation))
                        OP_CLEAR:  cell_ctrl.clear = 1'b1;
                        OP_FADE:   state_next = ST_PASS;
                        OP_SET:    state_next = ST_ANGLE;
                        OP_GLOW:   state_next = ST_ANGLE;
                        OP_ROTATE: state_next = ST_ROT;
                        OP_SHOW:   state_next = ST_PASS;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ANGLE:
            begin
                if (hd_done)
                begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (adv)
                begin
                    cell_ctrl.shift_up = 1'b1;
                    cnt_next = pass_done ? '0 : cnt_reg + IDX_W'(1);
                    if (pass_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ROT:
            begin
                ticks_next           = rot_hit ? 16'd0 : ticks_inc;
                cell_ctrl.shift_up   = rot_hit && rot_up;
                cell_ctrl.shift_down = rot_hit && !rot_up;
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ticks_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ticks_reg <= ticks_next;
        end
    end

    // heading mapper
    rgbr_heading u_heading (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (hd_start),
        .heading (cmd.heading),
        .done    (hd_done),
        .centre  (centre)
    );

    // update unit sees the led at cell 0 and feeds the top of the chain
    rgbr_head #(
        .LED_COUNT (LED_COUNT)
    ) u_head (
        .cmd     (cmd_reg),
        .centre  (centre),
        .pos     (cnt_reg),
        .led_in  (ring[0]),
        .led_out (head_out)
    );

    // chain of cells, closed into a ring
    for (genvar i = 0; i < LED_COUNT; i++)
    begin : g_cell
        rgbr_led_t up_in;
        rgbr_led_t down_in;
        if (i == LED_COUNT - 1)
        begin : g_top
            assign up_in = head_out;
        end
        else
        begin : g_mid_up
            assign up_in = ring[i+1];
        end
        if (i == 0)
        begin : g_bottom
            assign down_in = ring[LED_COUNT-1];
        end
        else
        begin : g_mid_down
            assign down_in = ring[i-1];
        end
        rgbr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .from_up   (up_in),
            .from_down (down_in),
            .led       (ring[i])
        );
    end

    // output word register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv && show_pass)
        begin
            out_valid_next = 1'b1;
        end
        else if (led.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && show_pass)
        begin
            out_led_reg   <= ring[0];
            out_index_reg <= RGBR_IDX_W'(cnt_reg);
            out_last_reg  <= (cnt_reg == LAST_POS);
        end
    end

    assign led.valid     = out_valid_reg;
    assign led.out_index = out_index_reg;
    assign led.out_red   = {out_led_reg.r, 4'b0000};
    assign led.out_green = {out_led_reg.g, 4'b0000};
    assign led.out_blue  = {out_led_reg.b, 4'b0000};
    assign led.last      = out_last_reg;

    // checks
    `RGBR_ASSERT_NOW(a_last_index, clk, rst_n, led.valid && led.last,
        led.out_index == RGBR_IDX_W'(LED_COUNT - 1), "last word not on the final led")
    `RGBR_ASSERT_NEXT(a_pass_home, clk, rst_n, pass_done,
        (state_reg == ST_IDLE) && (cnt_reg == '0), "circulation did not end at home")
    `RGBR_ASSERT_NEXT(a_ticks_below, clk, rst_n,
        (state_reg == ST_ROT) && (period_reg != 16'sd0),
        ticks_reg < mag, "tick counter left at or above the period")
    `RGBR_ASSERT_NOW(a_words_in_show, clk, rst_n, adv && show_pass,
        !out_valid_reg || led.ready, "show word overwrote a pending word")

endmodule

[rtl/rgbr_cell.sv]
// one ring cell: holds one led and takes a neighbor's value on a shift
module rgbr_cell
    import rgbr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  rgbr_cell_ctrl_t ctrl,
    input  rgbr_led_t       from_up,
    input  rgbr_led_t       from_down,
    output rgbr_led_t       led
);

    rgbr_led_t led_reg;
    rgbr_led_t led_next;

    // clear wins, then shift up, then shift down
    always_comb
    begin
        led_next = led_reg;
        if (ctrl.clear)
        begin
            led_next = '0;
        end
        else if (ctrl.shift_up)
        begin
            led_next = from_up;
        end
        else if (ctrl.shift_down)
        begin
            led_next = from_down;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg <= '0;
        end
        else
        begin
            led_reg <= led_next;
        end
    end

    assign led = led_reg;

endmodule

[rtl/rgbr_heading.sv]
// heading to led mapping, three registered steps: reduce mod 360 then pick the segment
module rgbr_heading
    import rgbr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [15:0]    heading,
    output logic                  done,
    output logic [RGBR_IDX_W-1:0] centre
);

    localparam logic [16:0] OFFSET = 17'd36000;   // 100 turns keeps the value positive
    localparam logic [15:0] RECIP  = 16'd46603;   // floor(2^24 / 360)
    localparam logic [8:0]  TURN   = 9'd360;

    logic        v1_reg, v2_reg, v3_reg;
    logic [16:0] u_reg;
    logic [7:0]  q_reg;
    logic [8:0]  h_reg;
    logic [RGBR_IDX_W-1:0] centre_reg;

    logic signed [17:0] u_wide;
    logic [16:0]        u_next;
    logic [32:0]        prod;
    logic [16:0]        rem;
    logic [16:0]        rem_fix;
    logic [8:0]         a_val;
    logic [13:0]        seg;
    logic [4:0]         pos;

    // step 1: offset and reciprocal multiply
    always_comb
    begin
        u_wide = 18'(heading) + 18'(OFFSET);
        u_next = u_wide[16:0];
        prod   = 33'(u_next) * 33'(RECIP);
    end

    // step 2: remainder with one correction
    always_comb
    begin
        rem     = u_reg - 17'(q_reg) * 17'(TURN);
        rem_fix = (rem >= 17'(TURN)) ? rem - 17'(TURN) : rem;
    end

    // step 3: 16-segment formula, 16 wraps to led 0
    always_comb
    begin
        a_val = TURN - h_reg;
        seg   = 14'(a_val) * 14'd23 + 14'd253;
        pos   = seg[13:9];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // centre is held from the last step until the next mapping
    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        q_reg <= prod[31:24];
        h_reg <= rem_fix[8:0];
        if (v2_reg)
        begin
            centre_reg <= (pos > 5'd15) ? '0 : pos[RGBR_IDX_W-1:0];
        end
    end

    assign done   = v3_reg;
    assign centre = centre_reg;

endmodule

[rtl/rgbr_head.sv]
// update unit at the ring's wrap point: fade, set or glow the led passing by
module rgbr_head
    import rgbr_pkg::*;
#(
    parameter int LED_COUNT = RGBR_LED_COUNT
)
(
    input  rgbr_cmd_t                     cmd,
    input  logic [RGBR_IDX_W-1:0]         centre,
    input  logic [$clog2(LED_COUNT)-1:0]  pos,
    input  rgbr_led_t                     led_in,
    output rgbr_led_t                     led_out
);

    localparam int IDX_W = $clog2(LED_COUNT);

    logic [IDX_W-1:0] fwd;
    logic [IDX_W-1:0] bwd;
    logic [IDX_W-1:0] gap;
    logic             near;

    // glow level for one channel at distance d, saturating add
    function automatic logic [7:0] glow_ch(input logic [7:0] c, input logic [7:0] cur,
                                           input logic [1:0] d);
        logic [8:0] lvl;
        logic [8:0] sum;
        lvl = {1'b0, c} - {1'b0, d, 6'b0};
        if (lvl[8])
        begin
            lvl = '0;
        end
        sum = lvl + {1'b0, cur};
        return sum[8] ? 8'hFF : sum[7:0];
    endfunction

    // circular distance to the centre led
    always_comb
    begin
        fwd  = pos - IDX_W'(centre);
        bwd  = IDX_W'(centre) - pos;
        gap  = (fwd < bwd) ? fwd : bwd;
        near = (gap <= IDX_W'(3));
    end

    always_comb
    begin
        led_out = led_in;
        case (cmd.op)
            OP_FADE:
            begin
                if (cmd.all_leds || (IDX_W'(cmd.led_index) == pos))
                begin
                    led_out.r = fade_ch(led_in.r, cmd.col.r, cmd.step);
                    led_out.g = fade_ch(led_in.g, cmd.col.g, cmd.step);
                    led_out.b = fade_ch(led_in.b, cmd.col.b, cmd.step);
                end
            end
            OP_SET:
            begin
                if (IDX_W'(centre) == pos)
                begin
                    led_out = cmd.col;
                end
            end
            OP_GLOW:
            begin
                if (near)
                begin
                    led_out.r = glow_ch(cmd.col.r, led_in.r, gap[1:0]);
                    led_out.g = glow_ch(cmd.col.g, led_in.g, gap[1:0]);
                    led_out.b = glow_ch(cmd.col.b, led_in.b, gap[1:0]);
                end
            end
            default:
            begin
                led_out = led_in;
            end
        endcase
    end

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the rgb led ring engine: directed table, then random commands
module tb;
    import rgbr_pkg::*;

    localparam int         STALL_LIMIT    = 5000;
    localparam int         TAIL_CYCLES    = 40;
    localparam int         RAND_PER_PHASE = 130;
    localparam logic [2:0] OP_SPARE_6     = 3'd6;
    localparam logic [2:0] OP_SPARE_7     = 3'd7;
    localparam logic [2:0] CMAP_SPARE     = 3'd7;

    typedef struct packed {
        logic [2:0]         op;
        logic [3:0]         led_index;
        logic               all_leds;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         step;
        logic signed [15:0] heading;
        logic signed [15:0] period;
        logic [2:0]         cmap;
        logic [11:0]        cval;
    } cmd_word_t;

    // one stimulus row; lit_on gives a show a typed-in uniform level for every led
    typedef struct packed {
        cmd_word_t  word;
        logic       lit_on;
        logic [7:0] lit;
    } dir_entry_t;

    typedef struct packed {
        logic [3:0]  idx;
        logic [11:0] r;
        logic [11:0] g;
        logic [11:0] b;
        logic        last;
    } led_word_t;

    logic clk;
    logic rst_n;

    rgbr_cmd_if cmd_bus ();
    rgbr_led_if led_bus ();

    rgb_led_ring_engine u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .led   (led_bus)
    );

    // predicted ring contents and tick counter
    rgbr_led_t   led_frame [RGBR_LED_COUNT];
    logic [15:0] tick_count;
    led_word_t   led_words_due [$];
    dir_entry_t  dir_tbl [$];
    int          mismatches    = 0;
    int          send_idle_pct = 31;
    int          rcv_idle_pct  = 75;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // one fade step on one channel, clamped at the target
    function automatic logic [7:0] fade_toward(logic [7:0] cur, logic [7:0] tgt,
                                               logic [7:0] stp);
        int cv;
        int tv;
        int sv;
        cv = cur;
        tv = tgt;
        sv = stp;
        if (cv > tv)
        begin
            return (cv - sv <= tv) ? tgt : 8'(cv - sv);
        end
        return (cv + sv >= tv) ? tgt : 8'(cv + sv);
    endfunction

    // heading in degrees to led number, segment 16 folds onto led 0
    function automatic int heading_led(logic signed [15:0] hd);
        int deg;
        int pos;
        deg = hd;
        deg = deg % 360;
        if (deg < 0)
        begin
            deg += 360;
        end
        pos = (23 * (360 - deg) + 253) >> 9;
        return (pos > 15) ? 0 : pos;
    endfunction

    // glow contribution at a distance, added with saturation
    function automatic logic [7:0] glow_sum(logic [7:0] cur, logic [7:0] col, int gap);
        int lvl;
        lvl = int'(col) - 64 * gap;
        if (lvl < 0)
        begin
            lvl = 0;
        end
        lvl += int'(cur);
        return (lvl > 255) ? 8'd255 : 8'(lvl);
    endfunction

    // colour of an angle command
    function automatic rgbr_led_t colour_for(cmd_word_t w);
        rgbr_led_t col;
        int        v;
        int        top;
        v     = w.cval;
        top   = v >> 4;
        col.r = w.red;
        col.g = w.green;
        col.b = w.blue;
        case (w.cmap)
            CMAP_GREY:
            begin
                col = {3{8'(top)}};
            end
            CMAP_STOP:
            begin
                col.b = 8'd0;
                if (v < 2048)
                begin
                    col.r = 8'(v >> 3);
                    col.g = 8'd255;
                end
                else
                begin
                    col.r = 8'd255;
                    col.g = 8'(255 - ((v - 2048) >> 3));
                end
            end
            CMAP_BLUE_RED:
            begin
                col.r = 8'(top);
                col.g = 8'd0;
                col.b = 8'(255 - top);
            end
            CMAP_RED:
            begin
                col = {8'(top), 16'd0};
            end
            CMAP_GREEN:
            begin
                col = {8'd0, 8'(top), 8'd0};
            end
            CMAP_BLUE:
            begin
                col = {16'd0, 8'(top)};
            end
            default:
            begin
            end
        endcase
        return col;
    endfunction

    // apply one accepted command to the predicted ring, queue led words for a show
    task automatic advance_frame(input dir_entry_t e);
        rgbr_led_t col;
        rgbr_led_t keep;
        led_word_t w;
        int        centre;
        int        pos;
        int        gap;
        int        mag;
        int        i;
        case (e.word.op)
            OP_CLEAR:
            begin
                for (i = 0; i < RGBR_LED_COUNT; i++)
                begin
                    led_frame[i] = '0;
                end
            end
            OP_FADE:
            begin
                for (i = 0; i < RGBR_LED_COUNT; i++)
                begin
                    if (e.word.all_leds || i == int'(e.word.led_index))
                    begin
                        led_frame[i].r = fade_toward(led_frame[i].r, e.word.red, e.word.step);
                        led_frame[i].g = fade_toward(led_frame[i].g, e.word.green, e.word.step);
                        led_frame[i].b = fade_toward(led_frame[i].b, e.word.blue, e.word.step);
                    end
                end
            end
            OP_SET:
            begin
                led_frame[heading_led(e.word.heading)] = colour_for(e.word);
            end
            OP_GLOW:
            begin
                col    = colour_for(e.word);
                centre = heading_led(e.word.heading);
                for (i = 0; i < 7; i++)
                begin
                    pos = (centre + RGBR_LED_COUNT - 3 + i) % RGBR_LED_COUNT;
                    gap = (i < 3) ? 3 - i : i - 3;
                    led_frame[pos].r = glow_sum(led_frame[pos].r, col.r, gap);
                    led_frame[pos].g = glow_sum(led_frame[pos].g, col.g, gap);
                    led_frame[pos].b = glow_sum(led_frame[pos].b, col.b, gap);
                end
            end
            OP_ROTATE:
            begin
                if (tick_count != 16'hFFFF)
                begin
                    tick_count++;
                end
                mag = e.word.period;
                if (mag < 0)
                begin
                    mag = -mag;
                end
                if (mag != 0 && int'(tick_count) >= mag)
                begin
                    // positive period moves every led one place toward index 0
                    if (e.word.period > 0)
                    begin
                        keep = led_frame[0];
                        for (i = 0; i < RGBR_LED_COUNT - 1; i++)
                        begin
                            led_frame[i] = led_frame[i + 1];
                        end
                        led_frame[RGBR_LED_COUNT - 1] = keep;
                    end
                    else
                    begin
                        keep = led_frame[RGBR_LED_COUNT - 1];
                        for (i = RGBR_LED_COUNT - 1; i > 0; i--)
                        begin
                            led_frame[i] = led_frame[i - 1];
                        end
                        led_frame[0] = keep;
                    end
                    tick_count = '0;
                end
            end
            OP_SHOW:
            begin
                for (i = 0; i < RGBR_LED_COUNT; i++)
                begin
                    col = led_frame[i];
                    if (e.lit_on)
                    begin
                        col = {3{e.lit}};
                    end
                    w.idx  = 4'(i);
                    w.r    = {col.r, 4'h0};
                    w.g    = {col.g, 4'h0};
                    w.b    = {col.b, 4'h0};
                    w.last = (i == RGBR_LED_COUNT - 1);
                    led_words_due.push_back(w);
                end
            end
            default:
            begin
                // spare operation codes leave everything as it is
            end
        endcase
    endtask

    task automatic drive_fields(input cmd_word_t w);
        cmd_bus.operation     <= w.op;
        cmd_bus.led_index     <= w.led_index;
        cmd_bus.all_leds      <= w.all_leds;
        cmd_bus.red           <= w.red;
        cmd_bus.green         <= w.green;
        cmd_bus.blue          <= w.blue;
        cmd_bus.step          <= w.step;
        cmd_bus.heading       <= w.heading;
        cmd_bus.rotate_period <= w.period;
        cmd_bus.color_map     <= w.cmap;
        cmd_bus.color_value   <= w.cval;
    endtask

    // offer one command word, wait for the handshake, then predict
    task automatic send_cmd(input dir_entry_t e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        drive_fields(e.word);
        do
        begin
            @(posedge clk);
        end
        while (cmd_bus.ready !== 1'b1);
        advance_frame(e);
    endtask

    function automatic dir_entry_t dir_entry(logic [2:0] op, logic [3:0] idx, logic every,
                                             logic [23:0] rgb, logic [7:0] stp,
                                             logic signed [15:0] hd, logic signed [15:0] per,
                                             logic [2:0] cmap, logic [11:0] cv,
                                             logic lit_on, logic [7:0] lit);
        dir_entry_t e;
        e.word.op        = op;
        e.word.led_index = idx;
        e.word.all_leds  = every;
        e.word.red       = rgb[23:16];
        e.word.green     = rgb[15:8];
        e.word.blue      = rgb[7:0];
        e.word.step      = stp;
        e.word.heading   = hd;
        e.word.period    = per;
        e.word.cmap      = cmap;
        e.word.cval      = cv;
        e.lit_on         = lit_on;
        e.lit            = lit;
        return e;
    endfunction

    // random command with every field filled, spare codes now and then
    function automatic dir_entry_t rand_cmd();
        dir_entry_t e;
        int         pick;
        e    = '0;
        pick = $urandom_range(99);
        if (pick < 5)
            e.word.op = OP_CLEAR;
        else if (pick < 30)
            e.word.op = OP_FADE;
        else if (pick < 50)
            e.word.op = OP_SET;
        else if (pick < 70)
            e.word.op = OP_GLOW;
        else if (pick < 85)
            e.word.op = OP_ROTATE;
        else if (pick < 97)
            e.word.op = OP_SHOW;
        else
            e.word.op = ($urandom_range(1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
        e.word.led_index = 4'($urandom_range(15));
        e.word.all_leds  = 1'($urandom_range(1));
        e.word.red       = 8'($urandom_range(255));
        e.word.green     = 8'($urandom_range(255));
        e.word.blue      = 8'($urandom_range(255));
        e.word.step      = ($urandom_range(1) != 0) ? 8'($urandom_range(12))
                                                    : 8'($urandom_range(255));
        e.word.heading   = 16'($urandom);
        // mostly short periods so the ring actually turns
        if ($urandom_range(3) != 0)
        begin
            e.word.period = 16'($urandom_range(8));
            if ($urandom_range(1) != 0)
            begin
                e.word.period = -e.word.period;
            end
        end
        else
        begin
            e.word.period = 16'($urandom);
        end
        e.word.cmap = 3'($urandom_range(7));
        e.word.cval = 12'($urandom_range(4095));
        return e;
    endfunction

    function automatic void check_field(string what, logic [11:0] want, logic [11:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    // led word checker
    always @(posedge clk)
    begin
        led_word_t want;
        if (rst_n && led_bus.valid === 1'b1 && led_bus.ready === 1'b1)
        begin
            if (led_words_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: led word expected none, got led %0d", $time, led_bus.out_index);
            end
            else
            begin
                want = led_words_due.pop_front();
                check_field("out_index", 12'(want.idx), 12'(led_bus.out_index));
                check_field("out_red", want.r, led_bus.out_red);
                check_field("out_green", want.g, led_bus.out_green);
                check_field("out_blue", want.b, led_bus.out_blue);
                check_field("last", 12'(want.last), 12'(led_bus.last));
            end
        end
    end

    // led word receiver stalls
    initial
    begin
        led_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            led_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // watchdog on cycles with no handshake on either channel
    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) ||
                (led_bus.valid === 1'b1 && led_bus.ready === 1'b1))
                stall = 0;
            else
                stall++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // stimulus
    initial
    begin
        dir_entry_t e;
        int         n;
        int         ph;
        int         k;
        rst_n         <= 1'b0;
        cmd_bus.valid <= 1'b0;
        drive_fields('0);
        for (k = 0; k < RGBR_LED_COUNT; k++)
        begin
            led_frame[k] = '0;
        end
        tick_count = '0;

        // directed rows: op, led, all, rgb, step, heading, period, map, value, typed, level
        // ring is dark out of reset
        dir_tbl.push_back(dir_entry(OP_SHOW, 0, 0, 0, 0, 0, 0, CMAP_DIRECT, 0, 1, 8'h00));
        // widest step takes every led straight to white
        dir_tbl.push_back(dir_entry(OP_FADE, 0, 1, 24'hFFFFFF, 255, 0, 0, CMAP_DIRECT, 0, 0, 0));
        dir_tbl.push_back(dir_entry(OP_SHOW, 0, 0, 0, 0, 0, 0, CMAP_DIRECT, 0, 1, 8'hFF));
        dir_tbl.push_back(dir_entry(OP_CLEAR, 0, 0, 0, 0, 0, 0, CMAP_DIRECT, 0, 0, 0));
        dir_tbl.push_back(dir_entry(OP_SHOW, 0, 0, 0, 0, 0, 0, CMAP_DIRECT, 0, 1, 8'h00));
        // zero step and partial steps up and back down on single leds, then a unit step on every led
        dir_tbl.push_back(dir_entry(OP_FADE, 5, 0, 24'hC80AFF, 0, 0, 0, CMAP_DIRECT, 0, 0, 0));
        dir_tbl.push_back(dir_entry(OP_FADE, 15, 0, 24'h6400FF, 60, 0, 0, CMAP_DIRECT, 0, 0, 0));
        dir_tbl.push_back(dir_entry(OP_FADE, 15, 0, 24'h000000, 30, 0, 0, CMAP_DIRECT, 0, 0, 0));
        dir_tbl.push_back(dir_entry(OP_FADE, 9, 1, 24'h808080, 1, 0, 0, CMAP_DIRECT, 0, 0, 0));
        // heading 0 lands on segment 16, folded onto led 0
        dir_tbl.push_back(dir_entry(OP_SET, 0, 0, 24'hFF0080, 0, 0, 0, CMAP_DIRECT, 0, 0, 0));
        dir_tbl.push_back(dir_entry(OP_SET, 0, 0, 0, 0, -32768, 0, CMAP_GREY, 4095, 0, 0));
        // stoplight on both sides of its midpoint
        dir_tbl.push_back(dir_entry(OP_SET, 0, 0, 0, 0, 32767, 0, CMAP_STOP, 2047, 0, 0));
        dir_tbl.push_back(dir_entry(OP_SET, 0, 0, 0, 0, 359, 0, CMAP_STOP, 2048, 0, 0));
        // glows, one wrapping past led 0, stacked until channels saturate
        dir_tbl.push_back(dir_entry(OP_GLOW, 0, 0, 0, 0, 90, 0, CMAP_BLUE_RED, 4095, 0, 0));
        dir_tbl.push_back(dir_entry(OP_GLOW, 0, 0, 0, 0, -1, 0, CMAP_RED, 12'h800, 0, 0));
        dir_tbl.push_back(dir_entry(OP_GLOW, 0, 0, 0, 0, 180, 0, CMAP_GREEN, 4095, 0, 0));
        dir_tbl.push_back(dir_entry(OP_GLOW, 0, 0, 24'h102030, 0, 270, 0, CMAP_BLUE, 4095, 0, 0));
        // unused map code falls back to the rgb fields
        dir_tbl.push_back(dir_entry(OP_SET, 7, 1, 24'h010203, 9, 45, 0, CMAP_SPARE, 12'hABC, 0, 0));
        dir_tbl.push_back(dir_entry(OP_SHOW, 0, 0, 0, 0, 0, 0, CMAP_DIRECT, 0, 0, 0));
        // rotation both ways, no period, and the most negative period
        dir_tbl.push_back(dir_entry(OP_ROTATE, 0, 0, 0, 0, 0, 1, CMAP_DIRECT, 0, 0, 0));
        dir_tbl.push_back(dir_entry(OP_ROTATE, 0, 0, 0, 0, 0, -1, CMAP_DIRECT, 0, 0, 0));
        dir_tbl.push_back(dir_entry(OP_ROTATE, 0, 0, 0, 0, 0, 0, CMAP_DIRECT, 0, 0, 0));
        dir_tbl.push_back(dir_entry(OP_ROTATE, 0, 0, 0, 0, 0, -32768, CMAP_DIRECT, 0, 0, 0));
        // spare operation codes do nothing
        dir_tbl.push_back(dir_entry(OP_SPARE_6, 3, 1, 24'hFFFFFF, 255, 0, 1, CMAP_DIRECT, 0, 0, 0));
        dir_tbl.push_back(dir_entry(OP_SPARE_7, 3, 1, 0, 255, 0, -1, CMAP_GREY, 4095, 0, 0));
        dir_tbl.push_back(dir_entry(OP_SHOW, 0, 0, 0, 0, 0, 0, CMAP_DIRECT, 0, 0, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tbl[k])
        begin
            send_cmd(dir_tbl[k]);
        end

        // random commands under three stall patterns
        for (ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                send_idle_pct = 75;
                rcv_idle_pct  = 31;
            end
            else if (ph == 2)
            begin
                send_idle_pct = 0;
                rcv_idle_pct  = 0;
            end
            n = 0;
            while (n < RAND_PER_PHASE)
            begin
                e = rand_cmd();
                send_cmd(e);
                if (e.word.op <= OP_SHOW)
                begin
                    n++;
                end
            end
        end
        cmd_bus.valid <= 1'b0;

        // drain
        while (led_words_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[rgb_led_ring_engine.f]
+incdir+rtl
rtl/rgbr_pkg.sv
rtl/rgbr_if.sv
rtl/rgbr_cell.sv
rtl/rgbr_heading.sv
rtl/rgbr_head.sv
rtl/rgb_led_ring_engine.sv
tb/sv/tb.sv
